>>> rtl/core/sitda_pkg.sv
// Shared constants and control types for the signed integer to decimal text block.
package sitda_pkg;

  // Width of the integer taken from the input word (8..64).
  localparam int ValueWidth  = 64;
  // Magnitude bits shifted into the BCD register in each conversion cycle.
  localparam int BitsPerStep = 4;
  localparam int StepCount   = (ValueWidth + BitsPerStep - 1) / BitsPerStep;
  localparam int MagWidth    = StepCount * BitsPerStep;
  // Decimal digits that always cover a magnitude of up to 2^(ValueWidth-1).
  localparam int DigitCount  = (ValueWidth * 77) / 256 + 1;
  localparam int BcdWidth    = DigitCount * 4;
  localparam int StepCntW    = $clog2(StepCount + 1);
  localparam int DigitCntW   = $clog2(DigitCount + 1);

  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] MinusSign = 8'd45;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic convert;
    logic skip;
    logic shift;
    logic emit_sign;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic negative;
  } status_t;

endpackage

>>> rtl/core/sitda_datapath.sv
// Datapath: magnitude, shift-add-3 BCD conversion, leading zero drop and character output.
module sitda_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [63:0]            value_i,
  input  sitda_pkg::cmd_t        cmd_i,
  output sitda_pkg::status_t     status_o,
  output logic [7:0]             character_o,
  output logic                   last_o
);

  localparam int W  = sitda_pkg::ValueWidth;
  localparam int MW = sitda_pkg::MagWidth;
  localparam int BW = sitda_pkg::BcdWidth;

  logic [MW-1:0]                    mag_q, mag_d;
  logic [BW-1:0]                    bcd_q, bcd_d;
  logic                             neg_q, neg_d;
  logic [sitda_pkg::StepCntW-1:0]   step_q, step_d;
  logic [sitda_pkg::DigitCntW-1:0]  dig_q, dig_d;

  logic [W-1:0]  raw;
  logic [W-1:0]  mag_abs;
  logic [MW-1:0] mag_conv;
  logic [BW-1:0] bcd_conv;
  logic [3:0]    top_digit;

  // Take the magnitude in the value's own width; the most negative value wraps to 2^(W-1)
  assign raw     = value_i[W-1:0];
  assign mag_abs = raw[W-1] ? (~raw + {{(W-1){1'b0}}, 1'b1}) : raw;

  // Run a few shift-add-3 steps per cycle over all digits
  always_comb begin
    bcd_conv = bcd_q;
    mag_conv = mag_q;
    for (int k = 0; k < sitda_pkg::BitsPerStep; k++) begin
      for (int d = 0; d < sitda_pkg::DigitCount; d++) begin
        if (bcd_conv[d*4 +: 4] >= 4'd5) begin
          bcd_conv[d*4 +: 4] = bcd_conv[d*4 +: 4] + 4'd3;
        end
      end
      bcd_conv = {bcd_conv[BW-2:0], mag_conv[MW-1]};
      mag_conv = {mag_conv[MW-2:0], 1'b0};
    end
  end

  // Select register updates from the controller's command
  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    neg_d  = neg_q;
    step_d = step_q;
    dig_d  = dig_q;
    if (cmd_i.load) begin
      mag_d  = MW'(mag_abs);
      bcd_d  = '0;
      neg_d  = raw[W-1];
      step_d = '0;
      dig_d  = sitda_pkg::DigitCntW'(sitda_pkg::DigitCount);
    end else if (cmd_i.convert) begin
      mag_d  = mag_conv;
      bcd_d  = bcd_conv;
      step_d = step_q + 1'b1;
    end else if (cmd_i.skip || cmd_i.shift) begin
      bcd_d = {bcd_q[BW-5:0], 4'd0};
      dig_d = dig_q - 1'b1;
    end
  end

  // Hold the working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      dig_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      dig_q  <= dig_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign top_digit = bcd_q[BW-1 -: 4];

  // Report status to the controller
  assign status_o.conv_done = (step_q == sitda_pkg::StepCntW'(sitda_pkg::StepCount - 1));
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.one_left  = (dig_q == sitda_pkg::DigitCntW'(1));
  assign status_o.negative  = neg_q;

  // Drive the outgoing character word
  assign character_o = cmd_i.emit_sign ? sitda_pkg::MinusSign
                                       : (sitda_pkg::DigitBase + {4'd0, top_digit});
  assign last_o      = !cmd_i.emit_sign && (dig_q == sitda_pkg::DigitCntW'(1));

endmodule

>>> rtl/core/sitda_ctrl.sv
// Controller state machine: load, convert, drop leading zeros, emit sign and digits.
module sitda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                value_valid_i,
  output logic                value_ready_o,
  output logic                char_valid_o,
  input  logic                char_ready_i,
  input  sitda_pkg::status_t  status_i,
  output sitda_pkg::cmd_t     cmd_o
);

  sitda_pkg::state_e state_q, state_d;

  // Work out the next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sitda_pkg::StIdle: begin
        if (value_valid_i) state_d = sitda_pkg::StConv;
      end
      sitda_pkg::StConv: begin
        if (status_i.conv_done) state_d = sitda_pkg::StSkip;
      end
      sitda_pkg::StSkip: begin
        if (!status_i.top_zero || status_i.one_left) begin
          state_d = status_i.negative ? sitda_pkg::StSign : sitda_pkg::StEmit;
        end
      end
      sitda_pkg::StSign: begin
        if (char_ready_i) state_d = sitda_pkg::StEmit;
      end
      sitda_pkg::StEmit: begin
        if (char_ready_i && status_i.one_left) state_d = sitda_pkg::StIdle;
      end
      default: state_d = sitda_pkg::StIdle;
    endcase
  end

  // Drive handshakes and datapath commands
  always_comb begin
    value_ready_o   = 1'b0;
    char_valid_o    = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      sitda_pkg::StIdle: begin
        value_ready_o = 1'b1;
        cmd_o.load    = value_valid_i;
      end
      sitda_pkg::StConv: begin
        cmd_o.convert = 1'b1;
      end
      sitda_pkg::StSkip: begin
        cmd_o.skip = status_i.top_zero && !status_i.one_left;
      end
      sitda_pkg::StSign: begin
        char_valid_o    = 1'b1;
        cmd_o.emit_sign = 1'b1;
      end
      sitda_pkg::StEmit: begin
        char_valid_o = 1'b1;
        cmd_o.shift  = char_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitda_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Sequence: a word is loaded as it is taken, then converted by shift-add-3 steps, and its
//   leading zeros are dropped before the first character (the sign, if negative) is offered.
// Throughput: one number at a time; characters leave at one per cycle while char_ready_i
//   is high, and a new word is taken only once the last character of a number has left.
// Reset: rst_ni clears the controller to idle and drops any number in progress.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        value_valid_i,
  output logic        value_ready_o,
  input  logic [63:0] value_i,
  output logic        char_valid_o,
  input  logic        char_ready_i,
  output logic [7:0]  character_o,
  output logic        last_o
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;

  // Sequence the conversion and output words
  sitda_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_valid_i (value_valid_i),
    .value_ready_o (value_ready_o),
    .char_valid_o  (char_valid_o),
    .char_ready_i  (char_ready_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Convert and shift out digits
  sitda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
